// ===== design/rrca_pkg.sv =====
// Shared widths, result codes and slot layout for the reorder receiver.
package rrca_pkg;

	localparam int SEQ_W          = 16;
	localparam int HANDLE_W       = 16;
	localparam int WINDOW_DEFAULT = 32;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK     = 1'b1;

	typedef struct packed {
		logic                valid;
		logic                final_seg;
		logic [HANDLE_W-1:0] handle;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

endpackage

// ===== design/rrca_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module rrca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/reorder_receiver_with_cumulative_ack.sv =====
// Top level of the reorder receiver: slot ring sequencer and result register.
//
// After reset the block runs a clearing pass over the slot memory with busy
// high. An early item is stored in its slot and acknowledged, an item beyond
// the window is only acknowledged, and an old duplicate or an item after the
// final segment gives no result. An expected segment that ends the transfer
// gives one delivery result. Any other expected segment is delivered and
// acknowledged, then the buffered slots behind it are drained in order, one
// slot memory read per drained slot. Results come one per cycle, each on the
// ports for exactly one cycle with result_valid high, and the receiver cannot
// stall them; last_of_run marks the final result of an item.
module reorder_receiver_with_cumulative_ack #(
	parameter int WINDOW = rrca_pkg::WINDOW_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rrca_pkg::SEQ_W-1:0]    segment_index,
	input  logic [rrca_pkg::HANDLE_W-1:0] payload_handle,
	input  logic                          final_segment,
	output logic                          result_valid,
	output logic                          kind,
	output logic [rrca_pkg::SEQ_W-1:0]    delivered_index,
	output logic [rrca_pkg::HANDLE_W-1:0] delivered_handle,
	output logic [rrca_pkg::SEQ_W-1:0]    ack_next,
	output logic                          transfer_done,
	output logic                          last_of_run
);

	import rrca_pkg::*;

	localparam int AW = $clog2(WINDOW);
	localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_ACKW  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] a);
		logic [AW-1:0] r;
		if (a == LAST_SLOT) begin
			r = '0;
		end else begin
			r = a + 1'b1;
		end
		return r;
	endfunction

	state_t              state_q;
	logic [AW-1:0]       clr_q;
	logic [AW-1:0]       head_q;
	logic [AW-1:0]       guard_q;
	logic [SEQ_W-1:0]    exp_q;
	logic                finished_q;
	slot_t               cur_q;

	logic                valid_q;
	logic                kind_q;
	logic [SEQ_W-1:0]    index_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [SEQ_W-1:0]    ack_q;
	logic                done_q;
	logic                last_q;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	slot_t               mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	slot_t               mem_rdata;

	logic [SEQ_W-1:0]    delta;
	logic                in_window;
	logic [AW:0]         store_sum;
	logic [AW-1:0]       store_addr;
	logic [AW-1:0]       head_p1;
	logic [AW-1:0]       head_p2;
	logic                drain_last;
	logic                take;

	assign take      = start && (state_q == ST_IDLE) && !finished_q;
	assign delta     = segment_index - exp_q;
	assign in_window = (delta != '0) && (delta < SEQ_W'(WINDOW));
	assign store_sum = {1'b0, head_q} + {1'b0, delta[AW-1:0]};
	assign store_addr = (store_sum >= (AW+1)'(WINDOW)) ?
		AW'(store_sum - (AW+1)'(WINDOW)) : store_sum[AW-1:0];
	assign head_p1   = slot_inc(head_q);
	assign head_p2   = slot_inc(head_p1);
	assign drain_last = cur_q.final_seg || (guard_q == LAST_SLOT) || !mem_rdata.valid;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = head_p1;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_IDLE: begin
				if (take) begin
					if (delta == '0) begin
						mem_we = 1'b1;
						mem_re = 1'b1;
					end else if (in_window) begin
						mem_we    = 1'b1;
						mem_waddr = store_addr;
						mem_wdata = '{valid: 1'b1, final_seg: final_segment,
							handle: payload_handle};
					end
				end
			end
			ST_ACKW: begin
				mem_re = mem_rdata.valid;
			end
			ST_DRAIN: begin
				mem_we    = 1'b1;
				mem_re    = 1'b1;
				mem_raddr = head_p2;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	rrca_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(WINDOW)
	) u_slots (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			exp_q      <= '0;
			finished_q <= 1'b0;
			valid_q    <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_SLOT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (take) begin
						if (delta == '0) begin
							valid_q <= 1'b1;
							if (final_segment) begin
								finished_q <= 1'b1;
							end else begin
								exp_q   <= exp_q + 1'b1;
								head_q  <= head_p1;
								state_q <= ST_ACKW;
							end
						end else if (!delta[SEQ_W-1]) begin
							valid_q <= 1'b1;
						end
					end
				end
				ST_ACKW: begin
					valid_q <= 1'b1;
					if (mem_rdata.valid) begin
						state_q <= ST_DRAIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRAIN: begin
					valid_q <= 1'b1;
					if (cur_q.final_seg) begin
						finished_q <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						exp_q  <= exp_q + 1'b1;
						head_q <= head_p1;
						if (drain_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (delta == '0) begin
					kind_q   <= KIND_DELIVER;
					index_q  <= segment_index;
					handle_q <= payload_handle;
					ack_q    <= '0;
					done_q   <= final_segment;
					last_q   <= final_segment;
				end else begin
					kind_q   <= KIND_ACK;
					index_q  <= '0;
					handle_q <= '0;
					ack_q    <= exp_q;
					done_q   <= 1'b0;
					last_q   <= 1'b1;
				end
			end
			ST_ACKW: begin
				kind_q   <= KIND_ACK;
				index_q  <= '0;
				handle_q <= '0;
				ack_q    <= exp_q;
				done_q   <= 1'b0;
				last_q   <= !mem_rdata.valid;
				cur_q    <= mem_rdata;
				guard_q  <= AW'(1);
			end
			ST_DRAIN: begin
				kind_q   <= KIND_DELIVER;
				index_q  <= exp_q;
				handle_q <= cur_q.handle;
				ack_q    <= '0;
				done_q   <= cur_q.final_seg;
				last_q   <= drain_last;
				cur_q    <= mem_rdata;
				guard_q  <= guard_q + 1'b1;
			end
			default: begin
				last_q <= 1'b0;
			end
		endcase
	end

	assign busy             = (state_q != ST_IDLE);
	assign result_valid     = valid_q;
	assign kind             = kind_q;
	assign delivered_index  = index_q;
	assign delivered_handle = handle_q;
	assign ack_next         = ack_q;
	assign transfer_done    = done_q;
	assign last_of_run      = last_q;

endmodule
